[src/bnc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bnc_pkg;

  // Register widths fixed by the register map
  localparam int unsigned FIELD_WIDTH_W  = 6;
  localparam int unsigned FIELD_HEIGHT_W = 13;
  localparam int unsigned ROW_CNT_W      = 12;
  localparam int unsigned CFG_DATA_W     = 13;

  // Register indexes
  localparam logic CFG_FIELD_WIDTH  = 1'b0;
  localparam logic CFG_FIELD_HEIGHT = 1'b1;

  // Reset values of the registers
  localparam logic [FIELD_WIDTH_W-1:0]  FIELD_WIDTH_RST  = 6'd32;
  localparam logic [FIELD_HEIGHT_W-1:0] FIELD_HEIGHT_RST = 13'd1;

  // Largest field height; larger settings saturate here
  localparam logic [FIELD_HEIGHT_W-1:0] FIELD_HEIGHT_MAX = 13'd4096;

  localparam int unsigned MAX_WIDTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Work descriptor handed from the front to the back
  typedef struct packed {
    logic [FIELD_WIDTH_W-1:0] col;    // column of the accepted cell
    logic [FIELD_WIDTH_W-1:0] width;  // effective field width, 1..MAX_WIDTH
    logic                     do_e0;  // report row above, column col-1
    logic                     do_e1;  // report row above, last column
    logic                     do_fl;  // flush the whole current row
  } job_ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_E0,
    BK_E1,
    BK_FLUSH
  } bk_state_e;

endpackage

`default_nettype wire

[src/bnc_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bnc_fifo
  import bnc_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   not_empty_o,
  output logic [DATA_W-1:0]      head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/bnc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bnc_front
  import bnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cell_is_mine_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output job_ctrl_t                  q_ctrl_o,
  output logic [MAX_WIDTH-1:0]       q_above_o,
  output logic [MAX_WIDTH-1:0]       q_mid_o,
  output logic [MAX_WIDTH-1:0]       q_cur_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [FIELD_WIDTH_W-1:0]  fw_q;
  logic [FIELD_HEIGHT_W-1:0] fh_q;
  logic [CW-1:0]             col_q;
  logic [ROW_CNT_W-1:0]      row_q;
  logic [MAX_WIDTH-1:0]      above_q, mid_q, cur_q;

  logic [FIELD_WIDTH_W-1:0]  w6, wm1;
  logic [ROW_CNT_W-1:0]      hm1;
  logic [CW-1:0]             col;
  logic                      last_col, last_row, accept;
  logic [MAX_WIDTH-1:0]      mask, cur_next;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Clamp the registers to their meaningful ranges
  always_comb begin
    if (fw_q == '0) begin
      w6 = FIELD_WIDTH_W'(1);
    end else if (fw_q > FIELD_WIDTH_W'(MAX_WIDTH)) begin
      w6 = FIELD_WIDTH_W'(MAX_WIDTH);
    end else begin
      w6 = fw_q;
    end
    wm1 = w6 - FIELD_WIDTH_W'(1);
    if (fh_q == '0) begin
      hm1 = '0;
    end else if (fh_q >= FIELD_HEIGHT_MAX) begin
      hm1 = ROW_CNT_W'(FIELD_HEIGHT_MAX - FIELD_HEIGHT_W'(1));
    end else begin
      hm1 = ROW_CNT_W'(fh_q - FIELD_HEIGHT_W'(1));
    end
  end

  always_comb begin
    col = (FIELD_WIDTH_W'(col_q) >= w6) ? wm1[CW-1:0] : col_q;
    last_col = (FIELD_WIDTH_W'(col) == wm1);
    last_row = (row_q >= hm1);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (FIELD_WIDTH_W'(i) < w6);
    end
    cur_next      = cur_q;
    cur_next[col] = cell_is_mine_i;
  end

  // Classify the cell: which reports it releases
  always_comb begin
    q_push_o       = accept;
    q_ctrl_o.col   = FIELD_WIDTH_W'(col);
    q_ctrl_o.width = w6;
    q_ctrl_o.do_e0 = (row_q != '0) && (col != '0);
    q_ctrl_o.do_e1 = (row_q != '0) && last_col;
    q_ctrl_o.do_fl = last_col && last_row;
    q_above_o      = (row_q >= ROW_CNT_W'(2)) ? (above_q & mask) : '0;
    q_mid_o        = (row_q != '0) ? (mid_q & mask) : '0;
    q_cur_o        = cur_next & mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FIELD_WIDTH_RST;
      fh_q <= FIELD_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIELD_WIDTH:  fw_q <= cfg_data_i[FIELD_WIDTH_W-1:0];
        CFG_FIELD_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_CNT_W'(1);
      end else begin
        col_q <= col + CW'(1);
      end
    end
  end

  // Row stores: roll the window down at the end of each row but the last
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_next;
      if (last_col && !last_row) begin
        above_q <= mid_q;
        mid_q   <= cur_next;
      end
    end
  end

endmodule

`default_nettype wire

[src/bnc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bnc_back
  import bnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire job_ctrl_t            q_ctrl_i,
  input  wire logic [MAX_WIDTH-1:0] q_above_i,
  input  wire logic [MAX_WIDTH-1:0] q_mid_i,
  input  wire logic [MAX_WIDTH-1:0] q_cur_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      out_is_mine_o,
  output logic [3:0]                neighbor_mines_o,
  output logic                      row_end_o,
  output logic                      field_end_o,
  output logic                      run_last_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  bk_state_e            state_q, state_d;
  job_ctrl_t            ctrl_q;
  logic [MAX_WIDTH-1:0] above_q, mid_q, cur_q;
  logic [CW-1:0]        k_q, k_d;

  logic                 slot_free, advance, load, last;
  logic                 k_end;
  logic [CW-1:0]        sel_col;
  logic [MAX_WIDTH-1:0] row_t, row_m, row_b;
  logic [MAX_WIDTH+1:0] ext_t, ext_m, ext_b;
  logic [2:0]           win_t, win_m, win_b;
  logic [3:0]           sum;
  logic                 res_mine, res_row_end, res_field_end;

  logic                 out_valid_q;
  logic                 out_mine_q, row_end_q, field_end_q, run_last_q;
  logic [3:0]           count_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign advance   = (state_q != BK_IDLE) && slot_free;
  assign k_end     = (FIELD_WIDTH_W'(k_q) == ctrl_q.width - FIELD_WIDTH_W'(1));
  assign load      = q_valid_i && ((state_q == BK_IDLE) || (advance && last));
  assign q_pop_o   = load;

  // Report selection for the current step
  always_comb begin
    sel_col       = ctrl_q.col[CW-1:0];
    row_t         = above_q;
    row_m         = mid_q;
    row_b         = cur_q;
    res_row_end   = 1'b0;
    res_field_end = 1'b0;
    last          = 1'b0;
    case (state_q)
      BK_E0: begin
        sel_col = ctrl_q.col[CW-1:0] - CW'(1);
        last    = !ctrl_q.do_e1 && !ctrl_q.do_fl;
      end
      BK_E1: begin
        res_row_end = 1'b1;
        last        = !ctrl_q.do_fl;
      end
      BK_FLUSH: begin
        sel_col       = k_q;
        row_t         = mid_q;
        row_m         = cur_q;
        row_b         = '0;
        res_row_end   = k_end;
        res_field_end = k_end;
        last          = k_end;
      end
      default: ;
    endcase
    ext_t    = {1'b0, row_t, 1'b0};
    ext_m    = {1'b0, row_m, 1'b0};
    ext_b    = {1'b0, row_b, 1'b0};
    win_t    = ext_t[sel_col +: 3];
    win_m    = ext_m[sel_col +: 3];
    win_b    = ext_b[sel_col +: 3];
    res_mine = win_m[1];
    sum = 4'(win_t[0]) + 4'(win_t[1]) + 4'(win_t[2]) + 4'(win_m[0]) + 4'(win_m[2])
        + 4'(win_b[0]) + 4'(win_b[1]) + 4'(win_b[2]);
  end

  always_comb begin
    state_d = state_q;
    if (load) begin
      if (q_ctrl_i.do_e0) begin
        state_d = BK_E0;
      end else if (q_ctrl_i.do_e1) begin
        state_d = BK_E1;
      end else if (q_ctrl_i.do_fl) begin
        state_d = BK_FLUSH;
      end else begin
        state_d = BK_IDLE;
      end
    end else if (advance) begin
      if (last) begin
        state_d = BK_IDLE;
      end else begin
        case (state_q)
          BK_E0:    state_d = ctrl_q.do_e1 ? BK_E1 : BK_FLUSH;
          BK_E1:    state_d = BK_FLUSH;
          BK_FLUSH: state_d = BK_FLUSH;
          default:  state_d = BK_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    if ((state_q != BK_FLUSH) || (advance && last)) begin
      k_d = '0;
    end else if (advance) begin
      k_d = k_q + CW'(1);
    end else begin
      k_d = k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q  <= q_ctrl_i;
      above_q <= q_above_i;
      mid_q   <= q_mid_i;
      cur_q   <= q_cur_i;
    end
    if (advance) begin
      out_mine_q  <= res_mine;
      count_q     <= res_mine ? 4'd0 : sum;
      row_end_q   <= res_row_end;
      field_end_q <= res_field_end;
      run_last_q  <= last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_is_mine_o    = out_mine_q;
  assign neighbor_mines_o = count_q;
  assign row_end_o        = row_end_q;
  assign field_end_o      = field_end_q;
  assign run_last_o       = run_last_q;

endmodule

`default_nettype wire

[src/binary_neighbor_count_3x3.sv]
// Streaming 3x3 mine-neighbour counter.
// Feed the cells of a binary field in row-major order on the input channel,
// one cell per transaction (cell_is_mine_i). Each result transaction reports
// one cell: whether it is a mine, else how many of its eight neighbours are
// mines; cells outside the field count as empty. A cell is reported once the
// row below it has reached its right-hand neighbour; the last cell of the
// field also flushes the whole last row as a burst. row_end_o, field_end_o
// and run_last_o mark the last cell of a row, of the field, and the last
// result caused by one input transaction.
// Set field_width (index 0) and field_height (index 1) through the write
// port while the block is idle; reset leaves width 32 and height 1.
// A result passes through the queue, the job registers of the report unit
// and the output register. The back end produces one result per cycle
// unless the receiver stalls, so throughput is one cell per cycle while each
// cell releases one result; a row end adds one, the field end the last row.
// A two-entry queue separates intake from reporting; when the receiver
// stalls, the output register holds its result, the queue fills and then
// in_stall_o rises. Reset empties the queue and clears the counters.
`timescale 1ns / 1ps
`default_nettype none

module binary_neighbor_count_3x3
  import bnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cell_is_mine_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       out_is_mine_o,
  output logic [3:0]                 neighbor_mines_o,
  output logic                       row_end_o,
  output logic                       field_end_o,
  output logic                       run_last_o
);

  // One queue entry: control word plus snapshots of the three rows
  localparam int unsigned JOB_W = $bits(job_ctrl_t) + 3 * MAX_WIDTH;

  logic                 q_full, q_push, q_pop, q_not_empty;
  job_ctrl_t            push_ctrl, head_ctrl;
  logic [MAX_WIDTH-1:0] push_above, push_mid, push_cur;
  logic [MAX_WIDTH-1:0] head_above, head_mid, head_cur;
  logic [JOB_W-1:0]     push_data, head_data;

  // Intake: keep the row window and decide which cells each transaction
  // releases
  bnc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cell_is_mine_i (cell_is_mine_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_ctrl_o       (push_ctrl),
    .q_above_o      (push_above),
    .q_mid_o        (push_mid),
    .q_cur_o        (push_cur)
  );

  assign push_data = {push_ctrl, push_above, push_mid, push_cur};
  assign {head_ctrl, head_above, head_mid, head_cur} = head_data;

  // Decoupling queue: the row snapshots travel with each job, so the intake
  // may start a new field while the last row still drains
  bnc_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (head_data)
  );

  // Reporting: count neighbours one cell per unstalled cycle into the output
  bnc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_not_empty),
    .q_ctrl_i         (head_ctrl),
    .q_above_i        (head_above),
    .q_mid_i          (head_mid),
    .q_cur_i          (head_cur),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_is_mine_o    (out_is_mine_o),
    .neighbor_mines_o (neighbor_mines_o),
    .row_end_o        (row_end_o),
    .field_end_o      (field_end_o),
    .run_last_o       (run_last_o)
  );

endmodule

`default_nettype wire
